// ===== rtl/ulrr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulrr_pkg: shared types and constants of the line ring receiver
// Item layouts, function and status codes, and the controller/datapath
// command and status groups.
// ----------------------------------------------------------------------------
package ulrr_pkg;

	// default geometry of the ring
	localparam int LINE_COUNT_DEF = 8;
	localparam int LINE_BYTES_DEF = 64;

	// field widths
	localparam int FUNC_W  = 2;
	localparam int BYTE_W  = 8;
	localparam int LIMIT_W = 6;
	localparam int STAT_W  = 2;
	localparam int LEN_W   = 6;

	// function codes
	localparam logic [FUNC_W-1:0] FUNC_RX    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

	// result status codes
	localparam logic [STAT_W-1:0] ST_DATA   = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOCOPY = 2'd2;

	// framing characters and fixed frame size
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h29;
	localparam int                FRAME_LEN = 9;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [BYTE_W-1:0]  rx_byte;
		logic [LIMIT_W-1:0] read_limit;
	} cmd_item_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [BYTE_W-1:0] data_byte;
		logic [LEN_W-1:0]  line_length;
		logic              last;
	} rsp_item_t;

	// controller -> datapath
	typedef struct packed {
		logic take;        // item accepted: latch it, start lookups
		logic clear;       // empty the ring
		logic rx_exec;     // store the received byte and update the ring
		logic line_start;  // begin streaming a popped line
		logic emit_empty;  // result: no line pending
		logic emit_nocopy; // result: line popped, nothing copied
		logic emit_byte;   // result: one line byte
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic line_empty;  // oldest slot holds no line
		logic n_zero;      // nothing to copy for this read
		logic out_free;    // output register can take a result
		logic byte_last;   // current byte is the final one of the read
	} dp_stat_t;

endpackage

// ===== rtl/ulrr_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulrr_stream_if: valid/ready channel
// Carries one item of type T per handshake.
// ----------------------------------------------------------------------------
interface ulrr_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/uart_line_ring_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_line_ring_receiver: receive ring of line slots
// Collects received bytes into a ring of line slots and hands back the
// oldest line on request.
// ----------------------------------------------------------------------------
// Channels: cmd takes one item per handshake (receive byte, read oldest
// line, clear); rsp returns result items, one per line byte copied, or a
// single status item; cfg writes the mode bit (fixed frames or console).
// The block works on one item at a time; cmd.ready is high when idle.
// Receive: the byte is latched on accept and stored in state S_RX, which
// waits on the registered store RAM read of the byte before it, which the
// CR-LF check needs. Clear and unused codes finish on accept.
// Read: the length RAM is read on accept and decoded in S_RLEN, then
// S_STREAM sends one byte per cycle from the store RAM read port while
// the output register is free. A status item goes through the state
// register and the output register; a data byte also through the RAM read.
// Results sit in an output register, so a read ends and the next item is
// taken while the final result still waits. If rsp.ready is low the byte
// stream stops and the store read data holds until the register drains.
// Reset clears pointers, fill count, slot valid bits, mode and the output
// register; the byte store itself is not cleared.
// ----------------------------------------------------------------------------
module uart_line_ring_receiver #(
	parameter int LINE_COUNT = ulrr_pkg::LINE_COUNT_DEF,
	parameter int LINE_BYTES = ulrr_pkg::LINE_BYTES_DEF
) (
	input logic           clk,
	input logic           arst_n,
	ulrr_stream_if.sink   cmd,
	ulrr_stream_if.source rsp,
	ulrr_stream_if.sink   cfg
);
	import ulrr_pkg::*;

	ctrl_cmd_t ctrl_cmd;
	dp_stat_t  dp_stat;
	logic      in_ready;
	logic      out_valid;
	rsp_item_t out_item;

	assign cmd.ready = in_ready;
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_valid;
	assign rsp.data  = out_item;

	ulrr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_func  (cmd.data.func),
		.in_ready (in_ready),
		.cmd      (ctrl_cmd),
		.stat     (dp_stat)
	);

	ulrr_dp #(
		.LINE_COUNT (LINE_COUNT),
		.LINE_BYTES (LINE_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (cmd.data),
		.cfg_we    (cfg.valid),
		.cfg_mode  (cfg.data),
		.cmd       (ctrl_cmd),
		.stat      (dp_stat),
		.out_valid (out_valid),
		.out_item  (out_item),
		.out_ready (rsp.ready)
	);
endmodule

// ===== rtl/ulrr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulrr_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data that holds
// while no read is issued.
// ----------------------------------------------------------------------------
module ulrr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== rtl/ulrr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulrr_ctrl: sequencer of the line ring receiver
// Accepts one item at a time and steps the datapath through receive,
// read and clear.
// ----------------------------------------------------------------------------
module ulrr_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [ulrr_pkg::FUNC_W-1:0] in_func,
	output logic                       in_ready,
	output ulrr_pkg::ctrl_cmd_t        cmd,
	input  ulrr_pkg::dp_stat_t         stat
);
	import ulrr_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_RX     = 2'd1;
	localparam logic [1:0] S_RLEN   = 2'd2;
	localparam logic [1:0] S_STREAM = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// next state and commands
	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					case (in_func)
						FUNC_RX:    state_d = S_RX;
						FUNC_READ:  state_d = S_RLEN;
						FUNC_CLEAR: cmd.clear = 1'b1;
						default:    ;
					endcase
				end
			end
			S_RX: begin
				cmd.rx_exec = 1'b1;
				state_d     = S_IDLE;
			end
			S_RLEN: begin
				if (stat.line_empty) begin
					if (stat.out_free) begin
						cmd.emit_empty = 1'b1;
						state_d        = S_IDLE;
					end
				end else if (stat.n_zero) begin
					if (stat.out_free) begin
						cmd.emit_nocopy = 1'b1;
						state_d         = S_IDLE;
					end
				end else begin
					cmd.line_start = 1'b1;
					state_d        = S_STREAM;
				end
			end
			S_STREAM: begin
				if (stat.out_free) begin
					cmd.emit_byte = 1'b1;
					if (stat.byte_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

// ===== rtl/ulrr_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulrr_dp: datapath of the line ring receiver
// Line store and length RAMs, slot pointers, fill count, per-slot valid
// bits, line framing decode and the output register.
// ----------------------------------------------------------------------------
module ulrr_dp #(
	parameter int LINE_COUNT = 8,
	parameter int LINE_BYTES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ulrr_pkg::cmd_item_t in_item,
	input  logic                cfg_we,
	input  logic                cfg_mode,
	input  ulrr_pkg::ctrl_cmd_t cmd,
	output ulrr_pkg::dp_stat_t  stat,
	output logic                out_valid,
	output ulrr_pkg::rsp_item_t out_item,
	input  logic                out_ready
);
	import ulrr_pkg::*;

	localparam int SW    = $clog2(LINE_COUNT);
	localparam int PW    = $clog2(LINE_BYTES);
	localparam int DEPTH = LINE_COUNT * LINE_BYTES;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = (PW > LIMIT_W) ? PW : LIMIT_W;

	logic                  mode_q;
	cmd_item_t             item_q;
	logic [SW-1:0]         ws_q;
	logic [SW-1:0]         rs_q;
	logic [PW-1:0]         fc_q;
	logic [LINE_COUNT-1:0] valid_q;
	logic [PW-1:0]         n_q;
	logic [PW-1:0]         idx_q;
	logic                  out_valid_q;
	rsp_item_t             out_item_q;

	logic                  st_re;
	logic [AW-1:0]         st_raddr;
	logic [AW-1:0]         st_waddr;
	logic [BYTE_W-1:0]     st_rdata;
	logic                  len_we;
	logic [PW-1:0]         len_rdata;

	logic [PW-1:0]         rx_n;
	logic                  rx_term;
	logic                  rx_commit;
	logic [PW-1:0]         rx_len;
	logic [SW-1:0]         ws_a;
	logic                  rx_stepback;
	logic [SW-1:0]         ws_b;
	logic [PW-1:0]         fc_d;
	logic [LINE_COUNT-1:0] valid_rx;

	logic [CW-1:0]         lim_w;
	logic [CW-1:0]         len_w;
	logic [PW-1:0]         n_d;
	logic                  pop;

	function automatic logic [SW-1:0] slot_next(input logic [SW-1:0] s);
		return (s == SW'(LINE_COUNT - 1)) ? '0 : s + SW'(1);
	endfunction

	function automatic logic [SW-1:0] slot_prev(input logic [SW-1:0] s);
		return (s == '0) ? SW'(LINE_COUNT - 1) : s - SW'(1);
	endfunction

	function automatic logic [AW-1:0] store_addr(input logic [SW-1:0] s,
	                                             input logic [PW-1:0] p);
		return AW'(32'(s) * LINE_BYTES + 32'(p));
	endfunction

	// receive decode: framing, commit and step-back decisions
	always_comb begin
		rx_n      = fc_q + PW'(1);
		rx_term   = mode_q && ((item_q.rx_byte == CH_CLOSE) ||
		            ((item_q.rx_byte == CH_LF) && (fc_q != '0) && (st_rdata == CH_CR)));
		rx_len    = rx_n;
		if (!mode_q) begin
			rx_commit = (rx_n >= PW'(FRAME_LEN));
		end else if (rx_term) begin
			rx_commit = (fc_q != '0);
			rx_len    = fc_q - PW'(1);
		end else begin
			rx_commit = (rx_n >= PW'(LINE_BYTES - 1));
		end
		ws_a        = rx_commit ? slot_next(ws_q) : ws_q;
		rx_stepback = mode_q && !rx_term && valid_q[ws_a];
		ws_b        = rx_stepback ? slot_prev(ws_a) : ws_a;
		fc_d        = (rx_commit || rx_term) ? '0 : rx_n;
	end

	// slot valid bits after a receive; step-back drops the slot, even one just committed
	always_comb begin
		valid_rx = valid_q;
		if (rx_commit) begin
			valid_rx[ws_q] = (rx_len != '0);
		end
		if (rx_stepback) begin
			valid_rx[ws_b] = 1'b0;
		end
	end

	// read decode: bytes to copy
	always_comb begin
		lim_w = CW'(item_q.read_limit);
		len_w = CW'(len_rdata);
		n_d   = PW'((lim_w < len_w) ? lim_w : len_w);
	end

	assign stat.line_empty = !valid_q[rs_q];
	assign stat.n_zero     = (n_d == '0);
	assign stat.out_free   = !out_valid_q || out_ready;
	assign stat.byte_last  = ((idx_q + PW'(1)) == n_q);

	assign pop = cmd.emit_nocopy || (cmd.emit_byte && stat.byte_last);

	// store read address: previous byte on receive, line bytes on read
	always_comb begin
		st_re = cmd.take || cmd.line_start || (cmd.emit_byte && !stat.byte_last);
		if (cmd.take) begin
			st_raddr = store_addr(ws_q, (fc_q == '0) ? '0 : fc_q - PW'(1));
		end else if (cmd.line_start) begin
			st_raddr = store_addr(rs_q, '0);
		end else begin
			st_raddr = store_addr(rs_q, idx_q + PW'(1));
		end
	end

	assign st_waddr = store_addr(ws_q, fc_q);
	assign len_we   = cmd.rx_exec && rx_commit;

	ulrr_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.rx_exec),
		.waddr (st_waddr),
		.wdata (item_q.rx_byte),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	ulrr_ram #(
		.WIDTH (PW),
		.DEPTH (LINE_COUNT)
	) u_lengths (
		.clk   (clk),
		.we    (len_we),
		.waddr (ws_q),
		.wdata (rx_len),
		.re    (cmd.take),
		.raddr (rs_q),
		.rdata (len_rdata)
	);

	// item latch
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			item_q <= in_item;
		end
	end

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q <= cfg_mode;
		end
	end

	// ring pointers, fill count and slot valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q    <= '0;
			rs_q    <= '0;
			fc_q    <= '0;
			valid_q <= '0;
		end else if (cmd.clear) begin
			ws_q    <= '0;
			rs_q    <= '0;
			fc_q    <= '0;
			valid_q <= '0;
		end else if (cmd.rx_exec) begin
			valid_q <= valid_rx;
			ws_q    <= ws_b;
			fc_q    <= fc_d;
		end else if (pop) begin
			valid_q[rs_q] <= 1'b0;
			rs_q          <= slot_next(rs_q);
		end
	end

	// line stream counters
	always_ff @(posedge clk) begin
		if (cmd.line_start) begin
			n_q   <= n_d;
			idx_q <= '0;
		end else if (cmd.emit_byte && !stat.byte_last) begin
			idx_q <= idx_q + PW'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_empty || cmd.emit_nocopy || cmd.emit_byte) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_empty) begin
			out_item_q <= '{status: ST_EMPTY, data_byte: '0, line_length: '0, last: 1'b1};
		end else if (cmd.emit_nocopy) begin
			out_item_q <= '{status: ST_NOCOPY, data_byte: '0,
			                line_length: LEN_W'(len_rdata), last: 1'b1};
		end else if (cmd.emit_byte) begin
			out_item_q <= '{status: ST_DATA, data_byte: st_rdata,
			                line_length: LEN_W'(len_rdata), last: stat.byte_last};
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
endmodule

// ===== tb/uart_line_ring_receiver_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_line_ring_receiver_tb: self-checking bench for the line ring receiver
// Drives receive/read/clear items and mode writes with random stalls on both
// channels. A tracker class mirrors the slot ring, predicts each read's
// result items and matches them in order against the rsp channel.
// ----------------------------------------------------------------------------
module uart_line_ring_receiver_tb;
	import ulrr_pkg::*;

	localparam int          NSLOT       = LINE_COUNT_DEF;
	localparam int          SLOT_BYTES  = LINE_BYTES_DEF;
	localparam int          RING_BYTES  = NSLOT * SLOT_BYTES;
	localparam logic [1:0]  FUNC_UNUSED = 2'd3;
	localparam logic        MODE_FIXED  = 1'b0;
	localparam logic        MODE_CONSOLE = 1'b1;
	localparam logic [5:0]  LIMIT_MAX   = 6'd63;
	localparam int          SETTLE_CYCLES = 4;
	localparam int          TAIL_CYCLES = 20;
	localparam int          STALL_LIMIT = 2000;

	// mirror of the slot ring; one expected result per copied byte or status
	class line_ring_tracker;
		logic [7:0]  slot_bytes [RING_BYTES];
		bit          stored [RING_BYTES];
		logic [5:0]  slot_len [NSLOT];
		int unsigned wr_slot;
		int unsigned fill;
		int unsigned rd_slot;
		logic        console_mode;
		rsp_item_t   due [$];
		int unsigned errors;

		function new();
			foreach (stored[i])
				stored[i] = 1'b0;
			console_mode = MODE_FIXED;
			errors = 0;
			wipe();
		endfunction

		function void wipe();
			wr_slot = 0;
			fill = 0;
			rd_slot = 0;
			foreach (slot_len[i])
				slot_len[i] = '0;
		endfunction

		function void set_mode(logic m);
			console_mode = m;
		endfunction

		function int unsigned outstanding();
			return due.size();
		endfunction

		function void commit(int unsigned len);
			slot_len[wr_slot] = 6'(len);
			fill = 0;
			wr_slot = (wr_slot + 1) % NSLOT;
		endfunction

		function void receive(logic [7:0] b);
			int unsigned base;
			base = wr_slot * SLOT_BYTES;
			slot_bytes[base + fill] = b;
			stored[base + fill] = 1'b1;
			fill++;
			if (console_mode == MODE_FIXED) begin
				if (fill >= FRAME_LEN)
					commit(fill);
				return;
			end
			// terminator: ')' or LF right after CR
			if (b == CH_CLOSE || (b == CH_LF && fill >= 2 &&
					slot_bytes[base + fill - 2] == CH_CR)) begin
				if (fill == 1)
					fill = 0;
				else
					commit(fill - 2);
				return;
			end
			if (fill >= SLOT_BYTES - 1)
				commit(fill);
			// next slot still unread: step back and reuse the previous one
			if (slot_len[wr_slot] != 0) begin
				wr_slot = (wr_slot == 0) ? NSLOT - 1 : wr_slot - 1;
				slot_len[wr_slot] = '0;
			end
		endfunction

		function void pop_line(logic [5:0] lim);
			rsp_item_t   r;
			int unsigned n;
			int unsigned base;
			r = '0;
			if (slot_len[rd_slot] == 0) begin
				r.status = ST_EMPTY;
				r.last = 1'b1;
				due.push_back(r);
				return;
			end
			base = rd_slot * SLOT_BYTES;
			n = (lim < slot_len[rd_slot]) ? lim : slot_len[rd_slot];
			r.line_length = slot_len[rd_slot];
			if (n == 0) begin
				r.status = ST_NOCOPY;
				r.last = 1'b1;
				due.push_back(r);
			end else begin
				for (int unsigned i = 0; i < n; i++) begin
					r.status = ST_DATA;
					r.data_byte = slot_bytes[base + i];
					r.last = (i + 1 == n);
					due.push_back(r);
				end
			end
			slot_len[rd_slot] = '0;
			rd_slot = (rd_slot + 1) % NSLOT;
		endfunction

		function void take_cmd(cmd_item_t c);
			case (c.func)
				FUNC_RX: receive(c.rx_byte);
				FUNC_READ: pop_line(c.read_limit);
				FUNC_CLEAR: wipe();
				default: ;
			endcase
		endfunction

		function void match_result(rsp_item_t got);
			rsp_item_t want;
			if (due.size() == 0) begin
				$display("%0t: result with nothing due: status %0d byte %02h length %0d last %0b",
					$time, got.status, got.data_byte, got.line_length, got.last);
				errors++;
				return;
			end
			want = due.pop_front();
			if (got.status !== want.status) begin
				$display("%0t: status mismatch: expected %0d, got %0d",
					$time, want.status, got.status);
				errors++;
			end
			if (got.data_byte !== want.data_byte) begin
				$display("%0t: data_byte mismatch: expected %02h, got %02h",
					$time, want.data_byte, got.data_byte);
				errors++;
			end
			if (got.line_length !== want.line_length) begin
				$display("%0t: line_length mismatch: expected %0d, got %0d",
					$time, want.line_length, got.line_length);
				errors++;
			end
			if (got.last !== want.last) begin
				$display("%0t: last mismatch: expected %0b, got %0b",
					$time, want.last, got.last);
				errors++;
			end
		endfunction

		// keep a read inside the bytes this slot has really had written
		function logic [5:0] safe_limit(logic [5:0] want);
			int unsigned k;
			int unsigned base;
			base = rd_slot * SLOT_BYTES;
			k = 0;
			if (slot_len[rd_slot] == 0)
				return want;
			while (k < slot_len[rd_slot] && stored[base + k])
				k++;
			return (want > k) ? 6'(k) : want;
		endfunction

		// the CR-LF check looks at the previous slot byte; it must be written
		function logic [7:0] safe_byte(logic [7:0] b);
			if (console_mode == MODE_CONSOLE && b == CH_LF && fill >= 1 &&
					!stored[wr_slot * SLOT_BYTES + fill - 1])
				return CH_CR;
			return b;
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	line_ring_tracker sb;
	bit               quiet_tail;
	int unsigned      stall_cycles;

	ulrr_stream_if #(.T(cmd_item_t)) cmd_if ();
	ulrr_stream_if #(.T(rsp_item_t)) rsp_if ();
	ulrr_stream_if #(.T(logic))      cfg_if ();

	uart_line_ring_receiver dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// result sink with random stall bursts
	initial begin
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				rsp_if.ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
		end
	end

	// result checking and no-progress watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready)
				sb.match_result(rsp_if.data);
			if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready) ||
					(cfg_if.valid && cfg_if.ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("uart_line_ring_receiver test failed");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	function automatic cmd_item_t make_cmd(logic [1:0] f, logic [7:0] b, logic [5:0] lim);
		cmd_item_t c;
		c.func = f;
		c.rx_byte = b;
		c.read_limit = lim;
		return c;
	endfunction

	// one item on cmd; valid stays high unless a gap follows
	task automatic send_cmd(input cmd_item_t c);
		cmd_if.valid <= 1'b1;
		cmd_if.data <= c;
		@(posedge clk);
		while (!cmd_if.ready)
			@(posedge clk);
		sb.take_cmd(c);
		if (!quiet_tail && $urandom_range(0, 5) == 0) begin
			cmd_if.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic send_rx(input logic [7:0] b);
		send_cmd(make_cmd(FUNC_RX, sb.safe_byte(b), 6'($urandom_range(0, 63))));
	endtask

	task automatic send_read(input logic [5:0] lim);
		send_cmd(make_cmd(FUNC_READ, 8'($urandom_range(0, 255)), sb.safe_limit(lim)));
	endtask

	// hold off until every due result is in and the last byte is stored
	task automatic settle();
		cmd_if.valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_mode(input logic m);
		settle();
		cfg_if.valid <= 1'b1;
		cfg_if.data <= m;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		sb.set_mode(m);
		cfg_if.valid <= 1'b0;
	endtask

	// random mix of lines, reads, clears and unused codes
	task automatic run_phase(input int unsigned quota, input int unsigned read_pct,
			input int unsigned max_body);
		int unsigned sent;
		int unsigned roll;
		int unsigned body;
		int unsigned term;
		logic [5:0]  lim;
		sent = 0;
		while (sent < quota) begin
			roll = $urandom_range(0, 99);
			if (roll < read_pct) begin
				lim = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 3))
					: 6'($urandom_range(0, 63));
				send_read(lim);
				sent++;
			end else if (roll < read_pct + 4) begin
				send_cmd(make_cmd(FUNC_CLEAR, 8'($urandom_range(0, 255)),
					6'($urandom_range(0, 63))));
				sent++;
			end else if (roll < read_pct + 6) begin
				send_cmd(make_cmd(FUNC_UNUSED, 8'($urandom_range(0, 255)),
					6'($urandom_range(0, 63))));
				sent++;
			end else begin
				if (sb.console_mode == MODE_CONSOLE)
					body = ($urandom_range(0, 15) == 0) ? $urandom_range(58, 66)
						: $urandom_range(0, max_body);
				else
					body = $urandom_range(1, max_body);
				for (int unsigned k = 0; k < body; k++)
					send_rx(8'($urandom_range(0, 255)));
				sent += body;
				if (sb.console_mode == MODE_CONSOLE) begin
					term = $urandom_range(0, 9);
					if (term < 5) begin
						send_rx(CH_CR);
						send_rx(CH_LF);
						sent += 2;
					end else if (term < 9) begin
						send_rx(CH_CLOSE);
						sent++;
					end
				end
			end
			if ($urandom_range(0, 59) == 0)
				settle();
		end
	endtask

	initial begin
		logic [7:0] frame [9];
		frame = '{8'h00, 8'hFF, CH_CR, CH_LF, CH_CLOSE, 8'h55, 8'hAA, 8'h01, 8'h80};
		sb = new();
		quiet_tail = 1'b0;
		stall_cycles = 0;
		arst_n <= 1'b0;
		cmd_if.valid <= 1'b0;
		cmd_if.data <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.data <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fixed frames: empty read, one frame of extreme bytes, pop without copy
		set_mode(MODE_FIXED);
		send_read(LIMIT_MAX);
		foreach (frame[i])
			send_rx(frame[i]);
		send_read(6'd0);
		send_cmd(make_cmd(FUNC_UNUSED, 8'hFF, LIMIT_MAX));
		send_cmd(make_cmd(FUNC_CLEAR, 8'h00, 6'd0));

		// console: leading ')' dropped, lone leading LF kept, CRLF line
		set_mode(MODE_CONSOLE);
		send_rx(CH_CLOSE);
		send_rx(CH_LF);
		send_rx(8'h41);
		send_rx(CH_CR);
		send_rx(CH_LF);
		send_read(LIMIT_MAX);
		// zero-length line leaves its slot empty
		send_rx(8'h42);
		send_rx(CH_CLOSE);
		send_read(LIMIT_MAX);
		send_cmd(make_cmd(FUNC_CLEAR, 8'hFF, LIMIT_MAX));

		// mode flipped mid-line: fixed commits at once with the full count
		for (int i = 0; i < 9; i++)
			send_rx(8'(8'h61 + i));
		set_mode(MODE_FIXED);
		send_rx(8'h7E);
		send_read(6'd5);

		// random phases
		set_mode(MODE_CONSOLE);
		run_phase(35, 35, 12);
		set_mode(MODE_FIXED);
		run_phase(30, 30, 12);
		set_mode(MODE_CONSOLE);
		run_phase(55, 3, 4);
		set_mode(MODE_FIXED);
		run_phase(25, 40, 12);
		set_mode(MODE_CONSOLE);
		quiet_tail = 1'b1;
		run_phase(35, 40, 10);

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("uart_line_ring_receiver test passed");
		else
			$display("uart_line_ring_receiver test failed");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/ulrr_pkg.sv
rtl/ulrr_stream_if.sv
rtl/ulrr_ram.sv
rtl/ulrr_ctrl.sv
rtl/ulrr_dp.sv
rtl/uart_line_ring_receiver.sv
tb/uart_line_ring_receiver_tb.sv
